// File: src/lsom_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// layer stack order manager. No dependencies.
package lsom_pkg;

    localparam int LAYER_COUNT = 256;
    localparam int POOL_SLOTS  = (LAYER_COUNT < 256) ? LAYER_COUNT : 256;
    localparam int IDX_W       = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int HEIGHT_W    = 9;

    localparam logic signed [HEIGHT_W-1:0] HIDDEN = {HEIGHT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_ALLOC      = 2'd0,
        CMD_SET_HEIGHT = 2'd1,
        CMD_FREE       = 2'd2,
        CMD_NOP        = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_OLD,
        ST_SH_RD,
        ST_SH_WR,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic use_sel_scan;
        logic scan_next;
        logic alloc_take;
        logic alloc_fail;
        logic reject;
        logic lh_rd;
        logic setup;
        logic nop_result;
        logic sh_rd;
        logic sh_wr;
        logic finish;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic id_valid;
        logic scan_free;
        logic scan_last;
        logic shift_done;
        logic out_free;
    } dp_status_t;

endpackage

// File: src/layer_stack_order_manager.sv
// Layer stack order manager: allocates layer slots and keeps their dense
// z-order stack. One command is in work at a time. Allocate walks the slot
// flags one per cycle until the lowest free slot or the last slot. Set-height
// and free shift the layers between the old and the new height; each shift
// step is a read and a write of the stack memory, which has one registered
// read port.
// A finished result sits in the output register while the next beat is taken.
// Top level; depends on lsom_pkg, lsom_ctrl and lsom_dp.
module layer_stack_order_manager
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [1:0]                              command,
    input  logic [7:0]                              layer_id,
    input  logic signed [lsom_pkg::HEIGHT_W-1:0]    requested_height,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [7:0]                              result_layer,
    output logic                                    ok,
    output logic signed [lsom_pkg::HEIGHT_W-1:0]    final_height,
    output logic signed [lsom_pkg::HEIGHT_W-1:0]    stack_top
);

    lsom_pkg::dp_cmd_t    dp_cmd;
    lsom_pkg::dp_status_t status;

    lsom_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .dp_cmd   (dp_cmd)
    );

    lsom_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .dp_cmd           (dp_cmd),
        .status           (status),
        .command          (command),
        .layer_id         (layer_id),
        .requested_height (requested_height),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .result_layer     (result_layer),
        .ok               (ok),
        .final_height     (final_height),
        .stack_top        (stack_top)
    );

endmodule

// File: src/lsom_ctrl.sv
// Controller state machine of the layer stack order manager.
// Depends on lsom_pkg; drives the datapath through dp_cmd_t.
module lsom_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lsom_pkg::dp_status_t status,
    output lsom_pkg::dp_cmd_t    dp_cmd
);

    lsom_pkg::state_t state_reg;
    lsom_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsom_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        in_ready   = 1'b0;
        case (state_reg)
            lsom_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = lsom_pkg::ST_DECODE;
                end
            end
            lsom_pkg::ST_DECODE:
            begin
                if (status.cmd == lsom_pkg::CMD_ALLOC)
                begin
                    state_next = lsom_pkg::ST_SCAN;
                end
                else if (!status.id_valid)
                begin
                    dp_cmd.reject = 1'b1;
                    state_next    = lsom_pkg::ST_DONE;
                end
                else
                begin
                    dp_cmd.lh_rd = 1'b1;
                    state_next   = lsom_pkg::ST_OLD;
                end
            end
            lsom_pkg::ST_SCAN:
            begin
                dp_cmd.use_sel_scan = 1'b1;
                if (status.scan_free)
                begin
                    dp_cmd.alloc_take = 1'b1;
                    state_next        = lsom_pkg::ST_DONE;
                end
                else if (status.scan_last)
                begin
                    dp_cmd.alloc_fail = 1'b1;
                    state_next        = lsom_pkg::ST_DONE;
                end
                else
                begin
                    dp_cmd.scan_next = 1'b1;
                end
            end
            lsom_pkg::ST_OLD:
            begin
                if (status.cmd == lsom_pkg::CMD_NOP)
                begin
                    dp_cmd.nop_result = 1'b1;
                    state_next        = lsom_pkg::ST_DONE;
                end
                else
                begin
                    dp_cmd.setup = 1'b1;
                    state_next   = lsom_pkg::ST_SH_RD;
                end
            end
            lsom_pkg::ST_SH_RD:
            begin
                if (status.shift_done)
                begin
                    state_next = lsom_pkg::ST_FINISH;
                end
                else
                begin
                    dp_cmd.sh_rd = 1'b1;
                    state_next   = lsom_pkg::ST_SH_WR;
                end
            end
            lsom_pkg::ST_SH_WR:
            begin
                dp_cmd.sh_wr = 1'b1;
                state_next   = lsom_pkg::ST_SH_RD;
            end
            lsom_pkg::ST_FINISH:
            begin
                dp_cmd.finish = 1'b1;
                state_next    = lsom_pkg::ST_DONE;
            end
            lsom_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    dp_cmd.load_out = 1'b1;
                    state_next      = lsom_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsom_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/lsom_dp.sv
// Datapath of the layer stack order manager: slot flags, height and stack
// memories, top register, shift counters and the output register.
// Depends on lsom_pkg; steered by lsom_ctrl.
module lsom_dp
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  lsom_pkg::dp_cmd_t                       dp_cmd,
    output lsom_pkg::dp_status_t                    status,
    input  logic [1:0]                              command,
    input  logic [7:0]                              layer_id,
    input  logic signed [lsom_pkg::HEIGHT_W-1:0]    requested_height,
    input  logic                                    out_ready,
    output logic                                    out_valid,
    output logic [7:0]                              result_layer,
    output logic                                    ok,
    output logic signed [lsom_pkg::HEIGHT_W-1:0]    final_height,
    output logic signed [lsom_pkg::HEIGHT_W-1:0]    stack_top
);

    localparam int IW = lsom_pkg::IDX_W;
    localparam int HW = lsom_pkg::HEIGHT_W;

    logic signed [HW-1:0]     lh_mem [lsom_pkg::POOL_SLOTS];
    logic [IW-1:0]            so_mem [lsom_pkg::POOL_SLOTS];

    logic [lsom_pkg::POOL_SLOTS-1:0] use_reg;
    logic signed [HW-1:0]     top_reg;
    logic                     out_valid_reg;

    lsom_pkg::cmd_t           cmd_reg;
    logic [7:0]               id_reg;
    logic signed [HW-1:0]     req_reg;
    logic [IW-1:0]            scan_reg;
    logic signed [HW-1:0]     old_reg;
    logic signed [HW-1:0]     want_reg;
    logic signed [HW-1:0]     dst_reg;
    logic signed [HW-1:0]     end_reg;
    logic                     dec_reg;
    logic signed [HW-1:0]     lh_rdata_reg;
    logic [IW-1:0]            so_rdata_reg;
    logic [7:0]               res_layer_reg;
    logic                     res_ok_reg;
    logic signed [HW-1:0]     res_fh_reg;
    logic [7:0]               result_layer_reg;
    logic                     ok_reg;
    logic signed [HW-1:0]     final_height_reg;
    logic signed [HW-1:0]     stack_top_reg;

    logic [IW-1:0]            s_idx;
    logic [IW-1:0]            use_addr;
    logic                     use_bit;
    logic                     in_pool;
    logic signed [HW-1:0]     src;
    logic signed [HW-1:0]     want_c;
    logic signed [HW-1:0]     start_c;
    logic signed [HW-1:0]     end_c;
    logic                     dec_c;
    logic                     lh_we;
    logic [IW-1:0]            lh_waddr;
    logic signed [HW-1:0]     lh_wdata;
    logic                     so_we;
    logic [IW-1:0]            so_waddr;
    logic [IW-1:0]            so_wdata;

    assign s_idx    = id_reg[IW-1:0];
    assign use_addr = dp_cmd.use_sel_scan ? scan_reg : s_idx;
    assign use_bit  = use_reg[use_addr];
    assign in_pool  = ({1'b0, id_reg} < 9'(lsom_pkg::POOL_SLOTS));
    assign src      = dec_reg ? (dst_reg - 9'sd1) : (dst_reg + 9'sd1);

    assign status.cmd        = cmd_reg;
    assign status.id_valid   = in_pool && use_bit;
    assign status.scan_free  = !use_bit;
    assign status.scan_last  = (scan_reg == IW'(lsom_pkg::POOL_SLOTS - 1));
    assign status.shift_done = (dst_reg == end_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        logic signed [HW:0] top_ext;
        logic signed [HW:0] bound;
        logic signed [HW:0] req_ext;
        logic signed [HW:0] tmp;
        top_ext = {top_reg[HW-1], top_reg};
        req_ext = {req_reg[HW-1], req_reg};
        bound   = lh_rdata_reg[HW-1] ? (top_ext + 10'sd1) : top_ext;
        tmp     = (req_ext > bound) ? bound : req_ext;
        if (tmp < -10'sd1)
        begin
            tmp = -10'sd1;
        end
        if (cmd_reg == lsom_pkg::CMD_FREE)
        begin
            want_c = lsom_pkg::HIDDEN;
        end
        else
        begin
            want_c = tmp[HW-1:0];
        end

        start_c = want_c;
        end_c   = want_c;
        dec_c   = 1'b0;
        if (lh_rdata_reg > want_c)
        begin
            start_c = lh_rdata_reg;
            if (!want_c[HW-1])
            begin
                dec_c = 1'b1;
            end
            else
            begin
                end_c = top_reg;
            end
        end
        else if (lh_rdata_reg < want_c)
        begin
            if (!lh_rdata_reg[HW-1])
            begin
                start_c = lh_rdata_reg;
            end
            else
            begin
                start_c = top_reg + 9'sd1;
                dec_c   = 1'b1;
            end
        end
    end

    always_comb
    begin
        lh_we    = 1'b0;
        lh_waddr = s_idx;
        lh_wdata = want_reg;
        so_we    = 1'b0;
        so_waddr = want_reg[IW-1:0];
        so_wdata = s_idx;
        if (dp_cmd.alloc_take)
        begin
            lh_we    = 1'b1;
            lh_waddr = scan_reg;
            lh_wdata = lsom_pkg::HIDDEN;
        end
        else if (dp_cmd.sh_wr)
        begin
            lh_we    = 1'b1;
            lh_waddr = so_rdata_reg;
            lh_wdata = dst_reg;
            so_we    = 1'b1;
            so_waddr = dst_reg[IW-1:0];
            so_wdata = so_rdata_reg;
        end
        else if (dp_cmd.finish)
        begin
            lh_we = 1'b1;
            so_we = !want_reg[HW-1] && (want_reg != old_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (lh_we)
        begin
            lh_mem[lh_waddr] <= lh_wdata;
        end
        if (dp_cmd.lh_rd)
        begin
            lh_rdata_reg <= lh_mem[s_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (so_we)
        begin
            so_mem[so_waddr] <= so_wdata;
        end
        if (dp_cmd.sh_rd)
        begin
            so_rdata_reg <= so_mem[src[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg       <= '0;
            top_reg       <= lsom_pkg::HIDDEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.alloc_take)
            begin
                use_reg[scan_reg] <= 1'b1;
            end
            if (dp_cmd.finish)
            begin
                if (cmd_reg == lsom_pkg::CMD_FREE)
                begin
                    use_reg[s_idx] <= 1'b0;
                end
                if (!old_reg[HW-1] && want_reg[HW-1])
                begin
                    top_reg <= top_reg - 9'sd1;
                end
                else if (old_reg[HW-1] && !want_reg[HW-1])
                begin
                    top_reg <= top_reg + 9'sd1;
                end
            end
            if (dp_cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg  <= lsom_pkg::cmd_t'(command);
            id_reg   <= layer_id;
            req_reg  <= requested_height;
            scan_reg <= '0;
        end
        if (dp_cmd.scan_next)
        begin
            scan_reg <= scan_reg + IW'(1);
        end
        if (dp_cmd.setup)
        begin
            old_reg  <= lh_rdata_reg;
            want_reg <= want_c;
            dst_reg  <= start_c;
            end_reg  <= end_c;
            dec_reg  <= dec_c;
        end
        if (dp_cmd.sh_wr)
        begin
            dst_reg <= src;
        end
        if (dp_cmd.alloc_take)
        begin
            res_layer_reg <= 8'(scan_reg);
            res_ok_reg    <= 1'b1;
            res_fh_reg    <= lsom_pkg::HIDDEN;
        end
        if (dp_cmd.alloc_fail)
        begin
            res_layer_reg <= '0;
            res_ok_reg    <= 1'b0;
            res_fh_reg    <= lsom_pkg::HIDDEN;
        end
        if (dp_cmd.reject)
        begin
            res_layer_reg <= id_reg;
            res_ok_reg    <= 1'b0;
            res_fh_reg    <= lsom_pkg::HIDDEN;
        end
        if (dp_cmd.nop_result)
        begin
            res_layer_reg <= id_reg;
            res_ok_reg    <= 1'b0;
            res_fh_reg    <= lh_rdata_reg;
        end
        if (dp_cmd.finish)
        begin
            res_layer_reg <= id_reg;
            res_ok_reg    <= 1'b1;
            res_fh_reg    <= want_reg;
        end
        if (dp_cmd.load_out)
        begin
            result_layer_reg <= res_layer_reg;
            ok_reg           <= res_ok_reg;
            final_height_reg <= res_fh_reg;
            stack_top_reg    <= top_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_layer = result_layer_reg;
    assign ok           = ok_reg;
    assign final_height = final_height_reg;
    assign stack_top    = stack_top_reg;

endmodule

// File: src/lsom_checker.sv
// Port-level checks for the layer stack order manager, bound to the top level.
// Depends on lsom_pkg for widths only.
module lsom_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [7:0]                           result_layer,
    input logic                                 ok,
    input logic signed [lsom_pkg::HEIGHT_W-1:0] final_height,
    input logic signed [lsom_pkg::HEIGHT_W-1:0] stack_top
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_layer) && $stable(ok)
            && $stable(final_height) && $stable(stack_top))
        else $error("Stalled result beat changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Second beat accepted while a command is in work.");

    a_height_below_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok |-> final_height <= stack_top)
        else $error("Successful result places the layer above the stack top.");

    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stack_top >= -9'sd1)
        else $error("Stack top below minus one.");

endmodule

bind layer_stack_order_manager lsom_checker u_lsom_checker (.*);

// File: tb/sv/layer_stack_order_manager_test.sv
// Self-checking testbench for layer_stack_order_manager: directed commands from a table,
// then random traffic that fills, reshuffles and drains the layer pool.
// Depends on lsom_pkg and the layer_stack_order_manager RTL.
module layer_stack_order_manager_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lsom_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 1925;
    localparam int EPOCH_ITEMS  = 300;
    localparam int DRAIN_CYCLES = 600;
    localparam int CYCLE_LIMIT  = 5_000_000;

    typedef struct {
        logic [7:0]                 layer;
        logic                       ok;
        logic signed [HEIGHT_W-1:0] height;
        logic signed [HEIGHT_W-1:0] top;
    } stack_result_t;

    typedef struct {
        cmd_t          cmd;
        logic [7:0]    id;
        int            req;
        bit            typed;
        stack_result_t fixed;
    } command_row_t;

    typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} traffic_mode_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 command;
    logic [7:0]                 layer_id;
    logic signed [HEIGHT_W-1:0] requested_height;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [7:0]                 result_layer;
    logic                       ok;
    logic signed [HEIGHT_W-1:0] final_height;
    logic signed [HEIGHT_W-1:0] stack_top;

    logic                       slot_used [POOL_SLOTS];
    logic signed [HEIGHT_W-1:0] layer_h   [LAYER_COUNT];
    logic [7:0]                 order_at  [LAYER_COUNT];
    logic signed [HEIGHT_W-1:0] top_h;
    int                         used_total;

    stack_result_t results_due [$];
    command_row_t  command_rows [$];
    int            fail_count = 0;
    int            cycle_count = 0;
    int            cmd_tally [4];
    int            full_refusals;
    int            peak_top;
    bit            steady = 1'b0;
    int            ready_hold = 0;

    layer_stack_order_manager dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .layer_id         (layer_id),
        .requested_height (requested_height),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_layer     (result_layer),
        .ok               (ok),
        .final_height     (final_height),
        .stack_top        (stack_top)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (steady)
            out_ready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold--;
        else if ($urandom_range(0, 1) == 1)
        begin
            out_ready <= 1'b1;
            ready_hold = $urandom_range(1, 20);
        end
        else
        begin
            out_ready <= 1'b0;
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                     : $urandom_range(0, 2);
        end
    end

    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result beat for layer %0d", result_layer);
                fail_count++;
            end
            else
            begin
                want = results_due.pop_front();
                if (result_layer !== want.layer)
                begin
                    $error("result_layer: expected %0d, got %0d", want.layer, result_layer);
                    fail_count++;
                end
                if (ok !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, ok);
                    fail_count++;
                end
                if (final_height !== want.height)
                begin
                    $error("final_height: expected %0d, got %0d", want.height, final_height);
                    fail_count++;
                end
                if (stack_top !== want.top)
                begin
                    $error("stack_top: expected %0d, got %0d", want.top, stack_top);
                    fail_count++;
                end
            end
        end
    end

    function automatic void restack(int s, int want);
        int old;
        int bound;
        int h;
        old = layer_h[s];
        bound = (old >= 0) ? int'(top_h) : int'(top_h) + 1;
        if (want > bound)
            want = bound;
        if (want < -1)
            want = -1;
        if (old > want)
        begin
            if (want >= 0)
            begin
                for (h = old; h > want; h--)
                begin
                    order_at[h] = order_at[h - 1];
                    layer_h[order_at[h]] = h[HEIGHT_W-1:0];
                end
                order_at[want] = s[7:0];
            end
            else
            begin
                for (h = old; h < int'(top_h); h++)
                begin
                    order_at[h] = order_at[h + 1];
                    layer_h[order_at[h]] = h[HEIGHT_W-1:0];
                end
                top_h = top_h - 9'sd1;
            end
        end
        else if (old < want)
        begin
            if (old >= 0)
            begin
                for (h = old; h < want; h++)
                begin
                    order_at[h] = order_at[h + 1];
                    layer_h[order_at[h]] = h[HEIGHT_W-1:0];
                end
            end
            else
            begin
                for (h = int'(top_h); h >= want; h--)
                begin
                    order_at[h + 1] = order_at[h];
                    layer_h[order_at[h + 1]] = HEIGHT_W'(h + 1);
                end
                top_h = top_h + 9'sd1;
            end
            order_at[want] = s[7:0];
        end
        layer_h[s] = want[HEIGHT_W-1:0];
    endfunction

    function automatic stack_result_t predict_command(cmd_t c, logic [7:0] id,
                                                      logic signed [HEIGHT_W-1:0] req);
        stack_result_t r;
        bit            live;
        int            i;
        r.layer = id;
        r.ok = 1'b0;
        r.height = HIDDEN;
        live = (int'(id) < POOL_SLOTS) && slot_used[id];
        case (c)
            CMD_ALLOC:
            begin
                r.layer = '0;
                for (i = 0; i < POOL_SLOTS; i++)
                begin
                    if (!slot_used[i])
                    begin
                        slot_used[i] = 1'b1;
                        layer_h[i] = HIDDEN;
                        r.layer = i[7:0];
                        r.ok = 1'b1;
                        used_total++;
                        break;
                    end
                end
            end
            CMD_SET_HEIGHT:
            begin
                if (live)
                begin
                    restack(int'(id), int'(req));
                    r.height = layer_h[id];
                    r.ok = 1'b1;
                end
            end
            CMD_FREE:
            begin
                if (live)
                begin
                    if (layer_h[id] >= 0)
                        restack(int'(id), -1);
                    slot_used[id] = 1'b0;
                    used_total--;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                if (live)
                    r.height = layer_h[id];
            end
        endcase
        r.top = top_h;
        return r;
    endfunction

    function automatic command_row_t row(cmd_t c, int id, int req, bit typed = 1'b0,
                                         int layer = 0, bit okay = 1'b0,
                                         int height = -1, int top = -1);
        command_row_t r;
        r.cmd = c;
        r.id = id[7:0];
        r.req = req;
        r.typed = typed;
        r.fixed.layer = layer[7:0];
        r.fixed.ok = okay;
        r.fixed.height = height[HEIGHT_W-1:0];
        r.fixed.top = top[HEIGHT_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic cmd_t pick_command(traffic_mode_t mode);
        int r;
        int alloc_w;
        int set_w;
        int free_w;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                alloc_w = 88;
                set_w = 97;
                free_w = 99;
            end
            MODE_MIX:
            begin
                alloc_w = 25;
                set_w = 75;
                free_w = 95;
            end
            default:
            begin
                alloc_w = 10;
                set_w = 45;
                free_w = 95;
            end
        endcase
        if (r < alloc_w)
            return CMD_ALLOC;
        if (r < set_w)
            return CMD_SET_HEIGHT;
        if (r < free_w)
            return CMD_FREE;
        return CMD_NOP;
    endfunction

    function automatic logic [7:0] pick_layer();
        int n;
        int i;
        if (used_total > 0 && $urandom_range(0, 99) < 85)
        begin
            n = $urandom_range(0, used_total - 1);
            for (i = 0; i < POOL_SLOTS; i++)
            begin
                if (slot_used[i])
                begin
                    if (n == 0)
                        return i[7:0];
                    n--;
                end
            end
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_height();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 15)
            return -1;
        if (r < 65)
            return $urandom_range(0, int'(top_h) + 1);
        if (r < 85)
        begin
            v = int'(top_h) + $urandom_range(0, 2);
            return (v > 255) ? 255 : v;
        end
        v = $urandom_range(0, 511);
        return (v >= 256) ? v - 512 : v;
    endfunction

    task automatic issue_command(command_row_t r);
        int            gap;
        stack_result_t got;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= r.cmd;
        layer_id <= r.id;
        requested_height <= r.req[HEIGHT_W-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = predict_command(r.cmd, r.id, r.req[HEIGHT_W-1:0]);
        results_due.push_back(r.typed ? r.fixed : got);
        cmd_tally[r.cmd]++;
        if (r.cmd == CMD_ALLOC && !got.ok)
            full_refusals++;
        if (int'(top_h) > peak_top)
            peak_top = int'(top_h);
    endtask

    initial
    begin
        traffic_mode_t mode;
        command_row_t  r;
        int            n;

        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_NOP;
        layer_id = '0;
        requested_height = '0;
        for (n = 0; n < POOL_SLOTS; n++)
            slot_used[n] = 1'b0;
        top_h = HIDDEN;
        used_total = 0;
        full_refusals = 0;
        peak_top = -1;
        for (n = 0; n < 4; n++)
            cmd_tally[n] = 0;

        command_rows.push_back(row(CMD_NOP, 0, 0, 1, 0, 0, -1, -1));
        command_rows.push_back(row(CMD_SET_HEIGHT, 0, 0, 1, 0, 0, -1, -1));
        command_rows.push_back(row(CMD_FREE, 255, 0, 1, 255, 0, -1, -1));
        command_rows.push_back(row(CMD_SET_HEIGHT, 128, -1, 1, 128, 0, -1, -1));
        command_rows.push_back(row(CMD_ALLOC, 0, 0, 1, 0, 1, -1, -1));
        command_rows.push_back(row(CMD_ALLOC, 0, 0, 1, 1, 1, -1, -1));
        command_rows.push_back(row(CMD_ALLOC, 255, 0, 1, 2, 1, -1, -1));
        command_rows.push_back(row(CMD_SET_HEIGHT, 0, 255, 1, 0, 1, 0, 0));
        command_rows.push_back(row(CMD_SET_HEIGHT, 1, -256, 1, 1, 1, -1, 0));
        command_rows.push_back(row(CMD_SET_HEIGHT, 1, 0));
        command_rows.push_back(row(CMD_SET_HEIGHT, 2, 1));
        command_rows.push_back(row(CMD_SET_HEIGHT, 0, 255));
        command_rows.push_back(row(CMD_SET_HEIGHT, 0, 2));
        command_rows.push_back(row(CMD_SET_HEIGHT, 0, 0));
        command_rows.push_back(row(CMD_SET_HEIGHT, 1, 1));
        command_rows.push_back(row(CMD_SET_HEIGHT, 2, -1));
        command_rows.push_back(row(CMD_SET_HEIGHT, 2, -5));
        command_rows.push_back(row(CMD_NOP, 1, 0));
        command_rows.push_back(row(CMD_FREE, 1, 0));
        command_rows.push_back(row(CMD_FREE, 2, 0));
        command_rows.push_back(row(CMD_ALLOC, 0, 0));
        command_rows.push_back(row(CMD_SET_HEIGHT, 1, 100));
        command_rows.push_back(row(CMD_NOP, 255, 0));
        command_rows.push_back(row(CMD_SET_HEIGHT, 0, -1));
        command_rows.push_back(row(CMD_FREE, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (command_rows[i])
            issue_command(command_rows[i]);

        mode = MODE_FILL;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % EPOCH_ITEMS == 0 && n != 0)
                mode = traffic_mode_t'($urandom_range(0, 2));
            if (n % 40 == 0)
                steady = ($urandom_range(0, 4) == 0);
            r.cmd = pick_command(mode);
            r.id = (r.cmd == CMD_ALLOC) ? 8'($urandom_range(0, 255)) : pick_layer();
            r.req = (r.cmd == CMD_SET_HEIGHT) ? pick_height()
                                              : int'($urandom_range(0, 511)) - 256;
            r.typed = 1'b0;
            issue_command(r);
        end
        in_valid <= 1'b0;
        steady = 1'b0;

        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Issued %0d commands: %0d allocate, %0d set height, %0d free, %0d no-op.",
                 cmd_tally[0] + cmd_tally[1] + cmd_tally[2] + cmd_tally[3],
                 cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3]);
        $display("Allocations refused on a full pool: %0d; highest stack top reached: %0d.",
                 full_refusals, peak_top);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
